>>> src/mpeck_pkg.sv
// ----------------------------------------------------------------------------
// mpeck_pkg
// Shared widths, register indexes and stage control for the masked pixel
// expand and color key pipeline.
// ----------------------------------------------------------------------------
package mpeck_pkg;

  // field widths
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned SRC_W  = 16;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 16;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_SRC16 = 3'd0;
  localparam logic [IDX_W-1:0] CFG_RED   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_GREEN = 3'd2;
  localparam logic [IDX_W-1:0] CFG_BLUE  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ALPHA = 3'd4;

  // register reset values
  localparam logic [SRC_W-1:0] RED_MASK_RST   = 16'hF800;
  localparam logic [SRC_W-1:0] GREEN_MASK_RST = 16'h07E0;
  localparam logic [SRC_W-1:0] BLUE_MASK_RST  = 16'h001F;
  localparam logic [SRC_W-1:0] ALPHA_MASK_RST = 16'h0000;

  // load enables for the four channel stages
  typedef struct packed {
    logic a;  // masked source
    logic b;  // aligned value times 255
    logic c;  // reciprocal product
    logic d;  // channel byte
  } stage_en_t;

endpackage

>>> src/mpeck_chan.sv
// ----------------------------------------------------------------------------
// mpeck_chan
// One color channel: mask, align, scale by 255/(2^n-1) through a reciprocal
// multiply, and keep the low byte of the quotient. Four register stages.
// ----------------------------------------------------------------------------
module mpeck_chan
  import mpeck_pkg::*;
(
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  logic [SRC_W-1:0] mask_i,
  input  logic [CH_W-1:0]  fill_i,
  input  logic [SRC_W-1:0] src_i,
  output logic [CH_W-1:0]  byte_o
);

  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SH_W   = 4;
  localparam int unsigned X_W    = 24;
  localparam int unsigned M_W    = 26;
  localparam int unsigned PROD_W = X_W + M_W;

  // position of the lowest set bit
  function automatic logic [SH_W-1:0] low_bit(input logic [SRC_W-1:0] m);
    logic [SH_W-1:0] s;
    s = '0;
    for (int i = SRC_W - 1; i >= 0; i--) begin
      if (m[i]) s = SH_W'(i);
    end
    return s;
  endfunction

  function automatic logic [CNT_W-1:0] pop_cnt(input logic [SRC_W-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < SRC_W; i++) begin
      c = c + CNT_W'(m[i]);
    end
    return c;
  endfunction

  // floor(2^(24+n)/(2^n-1)) + 1, exact quotient for any 24-bit dividend
  function automatic logic [M_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [M_W-1:0] r;
    case (n)
      5'd1:    r = 26'd33554433;
      5'd2:    r = 26'd22369622;
      5'd3:    r = 26'd19173962;
      5'd4:    r = 26'd17895698;
      5'd5:    r = 26'd17318417;
      5'd6:    r = 26'd17043522;
      5'd7:    r = 26'd16909321;
      5'd8:    r = 26'd16843010;
      5'd9:    r = 26'd16810049;
      5'd10:   r = 26'd16793617;
      5'd11:   r = 26'd16785413;
      5'd12:   r = 26'd16781314;
      5'd13:   r = 26'd16779265;
      5'd14:   r = 26'd16778241;
      5'd15:   r = 26'd16777729;
      5'd16:   r = 26'd16777473;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [SH_W-1:0]   shift_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [M_W-1:0]    m_q;
  logic [SRC_W-1:0]  masked_q;
  logic [SRC_W-1:0]  v;
  logic [X_W-1:0]    x_d, x_q;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [M_W-1:0]    hi_sh;
  logic [CH_W-1:0]   byte_d, byte_q;

  // mask decode, registered from the mask input
  always_ff @(posedge clk_i) begin
    shift_q <= low_bit(mask_i);
    cnt_q   <= pop_cnt(mask_i);
    m_q     <= recip(pop_cnt(mask_i));
  end

  // stage a: mask the source
  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      masked_q <= src_i & mask_i;
    end
  end

  // stage b: align and multiply by 255
  always_comb begin
    v   = masked_q >> shift_q;
    x_d = {v, 8'h00} - {8'h00, v};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      x_q <= x_d;
    end
  end

  // stage c: reciprocal product
  assign prod_d = PROD_W'(x_q) * PROD_W'(m_q);

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      prod_q <= prod_d;
    end
  end

  // stage d: quotient low byte, fill value for an empty mask
  always_comb begin
    hi_sh  = prod_q[PROD_W-1:X_W] >> cnt_q;
    byte_d = (cnt_q == '0) ? fill_i : hi_sh[CH_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.d) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

>>> src/masked_pixel_expand_color_key_top.sv
// ----------------------------------------------------------------------------
// masked_pixel_expand_color_key_top
// Expands a masked 16-bit or passes a 32-bit source pixel to 0xAARRGGBB and
// clears pixels that hit the magenta or green color key.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | sink      | in_valid_i/in_stall_o | pixel_in_i, last_in_i
//   out     | source    | out_valid_o/out_stall_i| pixel_out_o, keyed_o, last_out_o
//   cfg     | sink      | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i stays low; a beat reaches
// out_valid_o through the five register stages (mask, times 255, reciprocal
// multiply, channel byte, key), the first of which loads at the accepting edge.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles collapse and input is taken while a result waits.
// Reset clears all valid bits and loads the default masks and 32-bit mode.
// Register writes take effect for beats accepted on the following cycle.
// ----------------------------------------------------------------------------
module masked_pixel_expand_color_key_top
  import mpeck_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input beats
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PIX_W-1:0] pixel_in_i,
  input  logic             last_in_i,
  // output beats
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic             keyed_o,
  output logic             last_out_o,
  // register writes
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned N_ST = 5;
  localparam int unsigned KW   = CH_W + 1;

  localparam logic [CH_W-1:0] FILL_ZERO   = 8'h00;
  localparam logic [CH_W-1:0] FILL_OPAQUE = 8'hFF;
  localparam logic [KW-1:0]   MAG_HI      = 9'd250;
  localparam logic [KW-1:0]   MAG_LO      = 9'd5;
  localparam logic [KW-1:0]   GRN_MIN     = 9'd120;
  localparam logic [KW-1:0]   BAND1_MAX   = 9'd80;
  localparam logic [KW-1:0]   BAND1_GAP   = 9'd40;
  localparam logic [KW-1:0]   BAND2_MAX   = 9'd120;
  localparam logic [KW-1:0]   BAND2_GAP   = 9'd80;
  localparam logic [KW-1:0]   BAND2_GMIN  = 9'd180;

  logic             src16_q, src16_d;
  logic [SRC_W-1:0] red_q, red_d, green_q, green_d;
  logic [SRC_W-1:0] blue_q, blue_d, alpha_q, alpha_d;

  logic [N_ST-1:0]  valid_q;
  logic [N_ST-1:0]  ready;
  stage_en_t        en;

  logic [PIX_W-1:0] pix_a_q, pix_b_q, pix_c_q, pix_d_q;
  logic [3:0]       last_q;
  logic [CH_W-1:0]  r_ch, g_ch, b_ch, a_ch;

  logic [PIX_W-1:0] px;
  logic [KW-1:0]    kr, kg, kb;
  logic             alpha_nz, mag_hit, band1, band2, grn_hit, key_hit;
  logic [PIX_W-1:0] pix_out_q;
  logic             keyed_q, last_out_q;

  // register write decode
  always_comb begin
    src16_d = src16_q;
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    alpha_d = alpha_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SRC16: src16_d = cfg_data_i[0];
        CFG_RED:   red_d   = cfg_data_i;
        CFG_GREEN: green_d = cfg_data_i;
        CFG_BLUE:  blue_d  = cfg_data_i;
        CFG_ALPHA: alpha_d = cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src16_q <= 1'b0;
      red_q   <= RED_MASK_RST;
      green_q <= GREEN_MASK_RST;
      blue_q  <= BLUE_MASK_RST;
      alpha_q <= ALPHA_MASK_RST;
    end else begin
      src16_q <= src16_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
    end
  end

  // per-stage ready: load when empty or when the next stage moves
  always_comb begin
    ready[N_ST-1] = !valid_q[N_ST-1] || !out_stall_i;
    for (int i = N_ST - 2; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
    en.a = ready[0];
    en.b = ready[1];
    en.c = ready[2];
    en.d = ready[3];
  end

  assign in_stall_o = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      for (int i = 1; i < N_ST; i++) begin
        if (ready[i]) valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // pass-through pixel and end marker travel alongside the channels
  always_ff @(posedge clk_i) begin
    if (en.a) begin
      pix_a_q   <= pixel_in_i;
      last_q[0] <= last_in_i;
    end
    if (en.b) begin
      pix_b_q   <= pix_a_q;
      last_q[1] <= last_q[0];
    end
    if (en.c) begin
      pix_c_q   <= pix_b_q;
      last_q[2] <= last_q[1];
    end
    if (en.d) begin
      pix_d_q   <= pix_c_q;
      last_q[3] <= last_q[2];
    end
  end

  // channel units
  mpeck_chan u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .mask_i (red_q),
    .fill_i (FILL_ZERO),
    .src_i  (pixel_in_i[SRC_W-1:0]),
    .byte_o (r_ch)
  );

  mpeck_chan u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .mask_i (green_q),
    .fill_i (FILL_ZERO),
    .src_i  (pixel_in_i[SRC_W-1:0]),
    .byte_o (g_ch)
  );

  mpeck_chan u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .mask_i (blue_q),
    .fill_i (FILL_ZERO),
    .src_i  (pixel_in_i[SRC_W-1:0]),
    .byte_o (b_ch)
  );

  mpeck_chan u_alpha (
    .clk_i  (clk_i),
    .en_i   (en),
    .mask_i (alpha_q),
    .fill_i (FILL_OPAQUE),
    .src_i  (pixel_in_i[SRC_W-1:0]),
    .byte_o (a_ch)
  );

  // color key on the assembled pixel
  always_comb begin
    px       = src16_q ? {a_ch, r_ch, g_ch, b_ch} : pix_d_q;
    kb       = {1'b0, px[7:0]};
    kg       = {1'b0, px[15:8]};
    kr       = {1'b0, px[23:16]};
    alpha_nz = (px[31:24] != '0);
    mag_hit  = (kr >= MAG_HI) && (kg <= MAG_LO) && (kb >= MAG_HI);
    band1    = (kr <= BAND1_MAX) && (kb <= BAND1_MAX);
    band2    = !band1 && (kr <= BAND2_MAX) && (kb <= BAND2_MAX);
    grn_hit  = (kg >= GRN_MIN) &&
               ((band1 && (kg >= kr + BAND1_GAP) && (kg >= kb + BAND1_GAP)) ||
                (band2 && (kg >= kr + BAND2_GAP) && (kg >= kb + BAND2_GAP) &&
                 (kg >= BAND2_GMIN)));
    key_hit  = alpha_nz && (mag_hit || grn_hit);
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ready[N_ST-1]) begin
      pix_out_q  <= key_hit ? '0 : px;
      keyed_q    <= key_hit;
      last_out_q <= last_q[3];
    end
  end

  assign out_valid_o = valid_q[N_ST-1];
  assign pixel_out_o = pix_out_q;
  assign keyed_o     = keyed_q;
  assign last_out_o  = last_out_q;

`ifndef SYNTH
  // a keyed beat always carries a cleared pixel
  a_keyed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && keyed_o |-> pixel_out_o == '0)
    else $error("keyed beat with nonzero pixel");

  // transparent pixels never hit the key
  a_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alpha_nz |-> !key_hit)
    else $error("key hit on zero alpha");

  // input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a free stage");

  // the channel byte stage keeps a beat that cannot move
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] && !ready[3] |=> valid_q[3])
    else $error("beat lost in channel byte stage");
`endif

endmodule

>>> verif/masked_pixel_expand_color_key_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_pixel_expand_color_key_top_tb
// Drives single pixel beats through the expand and color key pipeline and
// compares every output beat against a fixed answer or an in-bench model of
// the unpack, scale and key logic. A short table covers key thresholds and
// mask corner cases; random phases then sweep masks with random idle and stall.
// ----------------------------------------------------------------------------
module masked_pixel_expand_color_key_top_tb
  import mpeck_pkg::*;
();

  // expected output beat
  typedef struct {
    logic [PIX_W-1:0] px;
    logic             keyed;
    logic             last;
  } pix_beat_t;

  // directed stimulus row: register setting, input beat, optional fixed answer
  typedef struct {
    logic             src16;
    logic [SRC_W-1:0] rm;
    logic [SRC_W-1:0] gm;
    logic [SRC_W-1:0] bm;
    logic [SRC_W-1:0] am;
    logic [PIX_W-1:0] px;
    logic             last;
    bit               fixed;
    logic [PIX_W-1:0] exp_px;
    logic             exp_key;
  } dir_row_t;

  localparam int NUM_DIR    = 25;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_LEN  = 65;
  localparam int MAX_IDLE   = 17;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [PIX_W-1:0] pixel_in_i;
  logic             last_in_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [PIX_W-1:0] pixel_out_o;
  logic             keyed_o;
  logic             last_out_o;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  // shadow copy of the register file
  logic             sh_src16;
  logic [SRC_W-1:0] sh_red;
  logic [SRC_W-1:0] sh_green;
  logic [SRC_W-1:0] sh_blue;
  logic [SRC_W-1:0] sh_alpha;

  pix_beat_t pending_pixels[$];
  int        mismatch_count;
  bit        send_quiet;
  bit        recv_quiet;
  bit        beat_taken;
  int        stall_left;

  dir_row_t dir_rows [NUM_DIR] = '{
    // pass-through with default masks
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'h00000000, 1'b0, 1, 32'h00000000, 1'b0},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFFFFFFFF, 1'b1, 1, 32'hFFFFFFFF, 1'b0},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFFFF00FF, 1'b0, 1, 32'h00000000, 1'b1},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'h00FF00FF, 1'b1, 1, 32'h00FF00FF, 1'b0},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFFFA05FA, 1'b0, 1, 32'h00000000, 1'b1},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFFF906FA, 1'b0, 0, 32'h0, 1'b0},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFF00FF00, 1'b1, 1, 32'h00000000, 1'b1},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFF507850, 1'b0, 1, 32'h00000000, 1'b1},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFF517851, 1'b0, 0, 32'h0, 1'b0},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFF78F878, 1'b0, 1, 32'h00000000, 1'b1},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFF78C778, 1'b1, 0, 32'h0, 1'b0},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFF79FF79, 1'b0, 0, 32'h0, 1'b0},
    '{1'b0, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'h01FF00FF, 1'b0, 1, 32'h00000000, 1'b1},
    // 565 unpack, upper half ignored
    '{1'b1, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hFFFF0000, 1'b0, 1, 32'hFF000000, 1'b0},
    '{1'b1, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'h0000FFFF, 1'b1, 1, 32'hFFFFFFFF, 1'b0},
    '{1'b1, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'h5A5AF81F, 1'b0, 1, 32'h00000000, 1'b1},
    '{1'b1, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'h000007E0, 1'b0, 1, 32'h00000000, 1'b1},
    '{1'b1, 16'hF800, 16'h07E0, 16'h001F, 16'h0000, 32'hA5A51234, 1'b1, 0, 32'h0, 1'b0},
    // every mask empty: opaque black
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hDEADBEEF, 1'b0, 1, 32'hFF000000, 1'b0},
    // every mask full width
    '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000FFFF, 1'b0, 1, 32'hFFFFFFFF, 1'b0},
    '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h00008000, 1'b1, 0, 32'h0, 1'b0},
    // split red mask, no compaction, byte wraps
    '{1'b1, 16'h0101, 16'h0000, 16'h0000, 16'h0000, 32'h00000101, 1'b0, 0, 32'h0, 1'b0},
    '{1'b1, 16'h0101, 16'h0000, 16'h0000, 16'h0000, 32'h00000100, 1'b1, 0, 32'h0, 1'b0},
    // 4444 with alpha in low nibble: zero alpha never keys
    '{1'b1, 16'hF000, 16'h0F00, 16'h00F0, 16'h000F, 32'h00000F00, 1'b0, 1, 32'h0000FF00, 1'b0},
    '{1'b1, 16'hF000, 16'h0F00, 16'h00F0, 16'h000F, 32'h00000F01, 1'b1, 1, 32'h00000000, 1'b1}
  };

  masked_pixel_expand_color_key_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_in_i  (pixel_in_i),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .keyed_o     (keyed_o),
    .last_out_o  (last_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // scale one masked channel up to a byte
  function automatic logic [7:0] expand_chan(logic [SRC_W-1:0] src, logic [SRC_W-1:0] mask,
                                             logic [7:0] empty_val);
    int unsigned lsb;
    int unsigned nbits;
    logic [31:0] val;
    logic [31:0] div;
    logic [31:0] quo;
    lsb   = 0;
    nbits = 0;
    for (int s = 0; s < SRC_W; s++) begin
      if (mask[s]) begin
        if (nbits == 0) lsb = s;
        nbits++;
      end
    end
    if (nbits == 0) return empty_val;
    val = 32'(src & mask) >> lsb;
    div = (32'd1 << nbits) - 32'd1;
    quo = (val * 32'd255) / div;
    return quo[7:0];
  endfunction

  // magenta or green-dominant key on an 0xAARRGGBB pixel
  function automatic bit key_hit(logic [PIX_W-1:0] px);
    int a, r, g, b, gr, gb;
    b  = int'(px[7:0]);
    g  = int'(px[15:8]);
    r  = int'(px[23:16]);
    a  = int'(px[31:24]);
    gr = g - r;
    gb = g - b;
    if (a == 0) return 0;
    if (r >= 250 && g <= 5 && b >= 250) return 1;
    if (g >= 120) begin
      if (r <= 80 && b <= 80) begin
        if (gr >= 40 && gb >= 40) return 1;
      end else if (r <= 120 && b <= 120) begin
        if (gr >= 80 && gb >= 80 && g >= 180) return 1;
      end
    end
    return 0;
  endfunction

  // expected output beat under the shadow registers
  function automatic pix_beat_t predict_pixel(logic [PIX_W-1:0] px, logic last);
    pix_beat_t res;
    logic [PIX_W-1:0] argb;
    logic [SRC_W-1:0] src;
    src  = px[SRC_W-1:0];
    argb = px;
    if (sh_src16) begin
      argb = {expand_chan(src, sh_alpha, 8'hFF), expand_chan(src, sh_red, 8'h00),
              expand_chan(src, sh_green, 8'h00), expand_chan(src, sh_blue, 8'h00)};
    end
    res.keyed = key_hit(argb);
    res.px    = res.keyed ? 32'h00000000 : argb;
    res.last  = last;
    return res;
  endfunction

  // random pixel biased toward the key bands
  function automatic logic [PIX_W-1:0] keyish_pixel();
    logic [7:0] a, r, g, b;
    a = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    case ($urandom_range(0, 4))
      1: begin
        r = 8'($urandom_range(244, 255));
        g = 8'($urandom_range(0, 10));
        b = 8'($urandom_range(244, 255));
      end
      2: begin
        r = 8'($urandom_range(0, 90));
        g = 8'($urandom_range(110, 255));
        b = 8'($urandom_range(0, 90));
      end
      3: begin
        r = 8'($urandom_range(70, 130));
        g = 8'($urandom_range(170, 255));
        b = 8'($urandom_range(70, 130));
      end
      default: return $urandom;
    endcase
    return {a, r, g, b};
  endfunction

  // random contiguous channel mask
  function automatic logic [SRC_W-1:0] run_mask();
    int w, lsb;
    w   = $urandom_range(1, 8);
    lsb = $urandom_range(0, SRC_W - w);
    return SRC_W'(((1 << w) - 1) << lsb);
  endfunction

  // hold off input until every outstanding beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
  endtask

  // write all five registers back to back; entered and left at a falling edge
  task automatic load_regs(logic [CFG_W-1:0] mode_word, logic [SRC_W-1:0] rm,
                           logic [SRC_W-1:0] gm, logic [SRC_W-1:0] bm, logic [SRC_W-1:0] am);
    logic [IDX_W-1:0] idx_list [5];
    logic [CFG_W-1:0] val_list [5];
    idx_list = '{CFG_SRC16, CFG_RED, CFG_GREEN, CFG_BLUE, CFG_ALPHA};
    val_list = '{mode_word, rm, gm, bm, am};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i  <= val_list[i];
      @(negedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cfg_data_i <= CFG_W'($urandom);
    @(negedge clk_i);
    sh_src16 = mode_word[0];
    sh_red   = rm;
    sh_green = gm;
    sh_blue  = bm;
    sh_alpha = am;
  endtask

  // one input beat; entered and left at a falling edge
  task automatic send_pixel(logic [PIX_W-1:0] px, logic last, bit fixed, pix_beat_t fixed_res);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    last_in_i  <= last;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_pixels.push_back(fixed ? fixed_res : predict_pixel(px, last));
    @(negedge clk_i);
  endtask

  // receiver stall: a fresh hold-off drawn after each taken beat
  always @(negedge clk_i) begin
    if (beat_taken) begin
      stall_left = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      beat_taken = 0;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each output beat with the oldest expectation
  always @(posedge clk_i) begin
    pix_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beat_taken = 1;
      if (pending_pixels.size() == 0) begin
        $error("unexpected output beat: pixel_out %h", pixel_out_o);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out_o !== want.px) begin
          $error("pixel_out: expected %h, got %h", want.px, pixel_out_o);
          mismatch_count++;
        end
        if (keyed_o !== want.keyed) begin
          $error("keyed: expected %b, got %b", want.keyed, keyed_o);
          mismatch_count++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, last_out_o);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("** masked_pixel_expand_color_key_top: FAILED **");
    $finish;
  end

  // main sequence
  initial begin
    pix_beat_t        fixed_res;
    logic [CFG_W-1:0] mode_word;
    logic [SRC_W-1:0] rm, gm, bm, am;
    logic [PIX_W-1:0] px;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    pixel_in_i     = '0;
    last_in_i      = 1'b0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_SRC16;
    cfg_data_i     = '0;
    mismatch_count = 0;
    send_quiet     = 0;
    recv_quiet     = 0;
    beat_taken     = 0;
    stall_left     = 0;
    sh_src16       = 1'b0;
    sh_red         = RED_MASK_RST;
    sh_green       = GREEN_MASK_RST;
    sh_blue        = BLUE_MASK_RST;
    sh_alpha       = ALPHA_MASK_RST;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table, registers reloaded whenever a row asks for new ones
    foreach (dir_rows[i]) begin
      if (dir_rows[i].src16 !== sh_src16 || dir_rows[i].rm !== sh_red ||
          dir_rows[i].gm !== sh_green || dir_rows[i].bm !== sh_blue ||
          dir_rows[i].am !== sh_alpha) begin
        drain();
        load_regs({15'd0, dir_rows[i].src16}, dir_rows[i].rm, dir_rows[i].gm,
                  dir_rows[i].bm, dir_rows[i].am);
      end
      fixed_res.px    = dir_rows[i].exp_px;
      fixed_res.keyed = dir_rows[i].exp_key;
      fixed_res.last  = dir_rows[i].last;
      send_pixel(dir_rows[i].px, dir_rows[i].last, dir_rows[i].fixed, fixed_res);
    end

    // random phases over a spread of mask settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      mode_word = {15'($urandom), 1'b1};
      case (ph)
        0: begin
          mode_word[0] = 1'b0;
          {rm, gm, bm, am} = {RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST, ALPHA_MASK_RST};
        end
        1: {rm, gm, bm, am} = {RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST, ALPHA_MASK_RST};
        2: {rm, gm, bm, am} = {16'h7C00, 16'h03E0, 16'h001F, 16'h8000};
        3: {rm, gm, bm, am} = {16'h0F00, 16'h00F0, 16'h000F, 16'hF000};
        4: {rm, gm, bm, am} = {16'h0000, 16'h0000, 16'h0000, 16'h0000};
        5: {rm, gm, bm, am} = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        6: {rm, gm, bm, am} = {run_mask(), run_mask(), run_mask(), run_mask()};
        8: begin
          mode_word[0] = 1'b0;
          {rm, gm, bm, am} = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        end
        default: begin
          mode_word[0] = 1'($urandom);
          {rm, gm, bm, am} = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        end
      endcase
      load_regs(mode_word, rm, gm, bm, am);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (sh_src16) begin
          px = $urandom;
        end else begin
          px = keyish_pixel();
        end
        send_pixel(px, 1'($urandom), 0, fixed_res);
      end
    end

    // let the pipe empty, then watch for strays
    drain();
    repeat (30) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("** masked_pixel_expand_color_key_top: PASSED **");
    end else begin
      $display("** masked_pixel_expand_color_key_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mpeck_pkg.sv
src/mpeck_chan.sv
src/masked_pixel_expand_color_key_top.sv
verif/masked_pixel_expand_color_key_top_tb.sv
